/* hdl/b64c_pkg.sv */
// b64c_pkg: shared types, constants and alphabet functions of the Base64 codec.
// No dependencies; imported by b64c_step, base64_codec_core and b64c_checker.
`default_nettype none

package b64c_pkg;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StLen  = 2'd1,
    StChar = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic [11:0] acc;
    logic [3:0]  held;
    logic [1:0]  grp;
    logic [1:0]  pads;
    logic        bad;
  } state_t;

  function automatic logic [7:0] enc_char(logic [5:0] idx);
    logic [7:0] w;
    w = {2'b00, idx};
    if (idx < 6'd26) return 8'(8'h41 + w);
    else if (idx < 6'd52) return 8'(8'h61 + w - 8'd26);
    else if (idx < 6'd62) return 8'(8'h30 + w - 8'd52);
    else if (idx == 6'd62) return 8'h2B;
    else return 8'h2F;
  endfunction

  // {valid, value}
  function automatic logic [6:0] dec_char(logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    case (c) inside
      [8'h41:8'h5A]: begin
        v = 8'(c - 8'h41);
        return {1'b1, v[5:0]};
      end
      [8'h61:8'h7A]: begin
        v = 8'(c - 8'h61 + 8'd26);
        return {1'b1, v[5:0]};
      end
      [8'h30:8'h39]: begin
        v = 8'(c - 8'h30 + 8'd52);
        return {1'b1, v[5:0]};
      end
      8'h2B: return {1'b1, 6'd62};
      8'h2F: return {1'b1, 6'd63};
      default: return 7'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

/* hdl/base64_codec_core.sv */
// base64_codec_core: top level of the streaming Base64 codec with APB register.
// Depends on b64c_pkg and b64c_step.
`default_nettype none

// Streaming Base64 codec, standard alphabet. Register 0 (byte address 0) bit 0
// selects the direction: 0 encodes bytes into characters with '=' padding on the
// last byte, 1 decodes characters into bytes and reports status on the result
// that carries out_last. Writing the register drops any partial message; write
// it only while idle. A transaction enters an input register, is processed
// combinationally into a result buffer of up to four entries, and the buffer
// drains one result per cycle while out_stall_i is low. Input is taken every
// cycle while the buffer is empty or passing its final entry, so an item with
// several results holds back the next: encoding gives four characters per three
// bytes (up to four for a padded final byte); decoding at most one byte per char.
module base64_codec_core import b64c_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_present_o,
  output logic             out_last_o,
  output logic [1:0]       status_o
);

  logic       dir_q;
  logic       cfg_wr;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  state_t     state_q, state_d;
  res_t [3:0] res_q, step_res;
  logic [2:0] cnt_q, step_cnt;
  logic       out_acc, in_acc, load;

  assign pready = 1'b1;
  assign prdata = {31'd0, dir_q};
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign load        = in_vld_q && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_acc));
  assign in_stall_o  = in_vld_q && !load;
  assign in_acc      = in_valid_i && !in_stall_o;

  b64c_step u_step (
    .dir_i   (dir_q),
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .res_o   (step_res),
    .count_o (step_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= 1'b0;
      state_q  <= '0;
      in_vld_q <= 1'b0;
      cnt_q    <= 3'd0;
    end else begin
      if (cfg_wr) begin
        dir_q   <= pwdata[0];
        state_q <= '0;
      end else if (load) begin
        state_q <= state_d;
      end
      if (in_acc) in_vld_q <= 1'b1;
      else if (load) in_vld_q <= 1'b0;
      if (load) cnt_q <= step_cnt;
      else if (out_acc) cnt_q <= 3'(cnt_q - 3'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
    if (load) begin
      res_q <= step_res;
    end else if (out_acc) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
      res_q[2] <= res_q[3];
    end
  end

  assign out_byte_o     = res_q[0].data;
  assign byte_present_o = res_q[0].present;
  assign out_last_o     = res_q[0].last;
  assign status_o       = res_q[0].status;

endmodule

`default_nettype wire

/* hdl/b64c_step.sv */
// b64c_step: combinational transaction step of the codec, encode and decode.
// Takes the message state and one item, gives up to four results and next state.
// Depends on b64c_pkg.
`default_nettype none

module b64c_step import b64c_pkg::*; (
  input  wire logic       dir_i,
  input  wire state_t     state_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output state_t          state_o,
  output res_t [3:0]      res_o,
  output logic [2:0]      count_o
);

  state_t     enc_st, dec_st;
  res_t [3:0] enc_r;
  res_t [3:0] dec_r;
  logic [2:0] enc_n, dec_n;

  logic [11:0] e_acc;
  logic [3:0]  e_rem;
  logic [5:0]  e_c0, e_c1;
  logic        e_two;

  always_comb begin
    e_acc = {state_i.acc[3:0], byte_i};
    e_c0  = e_acc[7:2];
    e_c1  = e_acc[5:0];
    e_rem = 4'd2;
    e_two = 1'b0;
    case (state_i.held)
      4'd2: begin
        e_c0  = e_acc[9:4];
        e_rem = 4'd4;
      end
      4'd4: begin
        e_c0  = e_acc[11:6];
        e_rem = 4'd0;
        e_two = 1'b1;
      end
      default: begin
        e_c0  = e_acc[7:2];
        e_rem = 4'd2;
      end
    endcase

    for (int i = 0; i < 4; i++) begin
      enc_r[i] = '{data: PadChar, present: 1'b1, last: 1'b0, status: StOk};
    end
    enc_r[0].data = enc_char(e_c0);
    enc_r[1].data = enc_char(e_c1);
    enc_n = e_two ? 3'd2 : 3'd1;
    if (last_i) begin
      if (e_rem == 4'd2) begin
        enc_r[1].data = enc_char({e_acc[1:0], 4'b0000});
        enc_n = 3'd4;
        enc_r[3].last = 1'b1;
      end else if (e_rem == 4'd4) begin
        enc_r[1].data = enc_char({e_acc[3:0], 2'b00});
        enc_n = 3'd3;
        enc_r[2].last = 1'b1;
      end else begin
        enc_r[1].last = 1'b1;
      end
    end

    enc_st = '0;
    if (!last_i) begin
      enc_st.acc  = e_acc;
      enc_st.held = e_rem;
    end
  end

  logic [6:0] d_val;
  logic       d_is_pad;
  logic [4:0] d_held;
  logic [7:0] d_byte;
  logic [1:0] d_st;

  always_comb begin
    d_val    = dec_char(byte_i);
    d_is_pad = (byte_i == PadChar) && state_i.grp[1];
    dec_st   = state_i;
    d_held   = {1'b0, state_i.held};
    if (d_is_pad) begin
      if (state_i.pads != 2'd2) dec_st.pads = 2'(state_i.pads + 2'd1);
    end else if (state_i.pads != 2'd0) begin
      dec_st.bad = 1'b1;
    end else begin
      if (!d_val[6]) dec_st.bad = 1'b1;
      dec_st.acc = {state_i.acc[5:0], d_val[6] ? d_val[5:0] : 6'd0};
      d_held     = 5'(state_i.held + 5'd6);
    end
    dec_st.grp = 2'(state_i.grp + 2'd1);

    d_st = StOk;
    if (last_i) begin
      if (dec_st.grp != 2'd0) d_st = StLen;
      else if (dec_st.bad) d_st = StChar;
    end

    case (d_held)
      5'd8:    d_byte = dec_st.acc[7:0];
      5'd9:    d_byte = dec_st.acc[8:1];
      5'd10:   d_byte = dec_st.acc[9:2];
      5'd11:   d_byte = dec_st.acc[10:3];
      default: d_byte = dec_st.acc[11:4];
    endcase

    dec_r    = '0;
    dec_n    = 3'd0;
    dec_st.held = d_held[3:0];
    if (d_held >= 5'd8) begin
      dec_r[0]    = '{data: d_byte, present: 1'b1, last: last_i, status: d_st};
      dec_n       = 3'd1;
      dec_st.held = 4'(d_held - 5'd8);
    end else if (last_i) begin
      dec_r[0] = '{data: 8'd0, present: 1'b0, last: 1'b1, status: d_st};
      dec_n    = 3'd1;
    end
    if (last_i) dec_st = '0;
  end

  assign state_o = dir_i ? dec_st : enc_st;
  assign res_o   = dir_i ? dec_r : enc_r;
  assign count_o = dir_i ? dec_n : enc_n;

endmodule

`default_nettype wire

/* hdl/b64c_checker.sv */
// b64c_checker: port-level assertions for base64_codec_core, bound to the top.
// Depends on b64c_pkg.
`default_nettype none

module b64c_checker import b64c_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       byte_present_o,
  input wire logic       out_last_o,
  input wire logic [1:0] status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("result transaction changed while stalled");

  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StOk) |-> out_last_o)
    else $error("nonzero status on a result that is not last");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_present_o |-> out_last_o && (out_byte_o == 8'd0))
    else $error("end-only marker malformed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StOk) || (status_o == StLen) || (status_o == StChar))
    else $error("status code out of range");

endmodule

bind base64_codec_core b64c_checker u_b64c_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_byte_o     (out_byte_o),
  .byte_present_o (byte_present_o),
  .out_last_o     (out_last_o),
  .status_o       (status_o)
);

`default_nettype wire
